// ===== rtl/rmch_pkg.sv =====
// Shared constants, types and helpers for the ray/mesh closest-hit block.
`timescale 1ns / 1ps

package rmch_pkg;

    // Parameter defaults
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Internal fixed-point widths: values saturate to +-(2^60 - 1)
    localparam int MAG_W       = 60;
    localparam int ACC_W       = MAG_W + 1;
    localparam int SUM_W       = MAG_W + 3;
    localparam int DIG_W       = 15;
    localparam int NDIG        = MAG_W / DIG_W;
    localparam int DIST_W      = 31;
    localparam int OUT_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int STEP_W      = 5;

    localparam logic [MAG_W-1:0]  MAG_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(MAG_MAX);
    localparam logic signed [SUM_W-1:0] OUT_HI  = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] OUT_LO  = -(SUM_W'(1) << (OUT_W - 1));

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        acc_t x;
        acc_t y;
        acc_t z;
    } vec3_t;

    // One triangle after edge setup, as queued between front and back
    typedef struct packed {
        vec3_t e1;
        vec3_t e2;
        vec3_t s;
        logic  last;
    } tri_item_t;

    typedef struct packed {
        logic start;
        acc_t a;
        acc_t b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        acc_t prod;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL_ISSUE,
        BK_MUL_WAIT,
        BK_CLASSIFY,
        BK_DIV_CHECK,
        BK_DIV_STEP,
        BK_UPDATE,
        BK_FINISH,
        BK_HIT_ISSUE,
        BK_HIT_WAIT,
        BK_EMIT
    } back_state_t;

    // Clamp a sum to the internal range
    function automatic acc_t sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            if (v > SUM_LIM)
                r = SUM_LIM;
            else if (v < -SUM_LIM)
                r = -SUM_LIM;
            else
                r = v;
            return acc_t'(r[ACC_W-1:0]);
        end
    endfunction

endpackage

// ===== rtl/rmch_if.sv =====
// Channel interfaces: triangle input, result output and configuration writes.
`timescale 1ns / 1ps

interface rmch_tri_if
    import rmch_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vert_a_x;
    logic signed [COORD_WIDTH-1:0] vert_a_y;
    logic signed [COORD_WIDTH-1:0] vert_a_z;
    logic signed [COORD_WIDTH-1:0] vert_b_x;
    logic signed [COORD_WIDTH-1:0] vert_b_y;
    logic signed [COORD_WIDTH-1:0] vert_b_z;
    logic signed [COORD_WIDTH-1:0] vert_c_x;
    logic signed [COORD_WIDTH-1:0] vert_c_y;
    logic signed [COORD_WIDTH-1:0] vert_c_z;
    logic                          last_triangle;

    modport source (
        output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z, last_triangle,
        input  ready
    );
    modport sink (
        input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z, last_triangle,
        output ready
    );
endinterface

interface rmch_hit_if
    import rmch_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    hit_found;
    logic [DIST_W-1:0]       nearest_dist;
    logic signed [OUT_W-1:0] hit_x;
    logic signed [OUT_W-1:0] hit_y;
    logic signed [OUT_W-1:0] hit_z;

    modport source (
        output valid, hit_found, nearest_dist, hit_x, hit_y, hit_z,
        input  ready
    );
    modport sink (
        input  valid, hit_found, nearest_dist, hit_x, hit_y, hit_z,
        output ready
    );
endinterface

interface rmch_cfg_if
    import rmch_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   idx;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface

// ===== rtl/rmch_fifo.sv =====
// Short queue of set-up triangles between front and back.
`timescale 1ns / 1ps

module rmch_fifo
    import rmch_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  tri_item_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output tri_item_t rd_data,
    output logic      empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tri_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Store items
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

// ===== rtl/rmch_front.sv =====
// Front end: accept triangles, form edge vectors and tag the last item.
`timescale 1ns / 1ps

module rmch_front
    import rmch_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    rmch_tri_if.sink  tri_in,
    input  vec3_t     origin,
    output logic      wr_en,
    output tri_item_t wr_data,
    input  logic      full
);
    // Sign-extend a coordinate to the internal width; the differences are not clamped here
    function automatic acc_t ext(input logic signed [COORD_WIDTH-1:0] v);
        return acc_t'(v);
    endfunction

    assign tri_in.ready = !full;
    assign wr_en        = tri_in.valid && !full;

    // Edge setup: e1 = b - a, e2 = c - a, s = origin - a
    always_comb
    begin
        wr_data.e1.x = ext(tri_in.vert_b_x) - ext(tri_in.vert_a_x);
        wr_data.e1.y = ext(tri_in.vert_b_y) - ext(tri_in.vert_a_y);
        wr_data.e1.z = ext(tri_in.vert_b_z) - ext(tri_in.vert_a_z);
        wr_data.e2.x = ext(tri_in.vert_c_x) - ext(tri_in.vert_a_x);
        wr_data.e2.y = ext(tri_in.vert_c_y) - ext(tri_in.vert_a_y);
        wr_data.e2.z = ext(tri_in.vert_c_z) - ext(tri_in.vert_a_z);
        wr_data.s.x  = origin.x - ext(tri_in.vert_a_x);
        wr_data.s.y  = origin.y - ext(tri_in.vert_a_y);
        wr_data.s.z  = origin.z - ext(tri_in.vert_a_z);
        wr_data.last = tri_in.last_triangle;
    end
endmodule

// ===== rtl/rmch_mulq.sv =====
// Shared fixed-point multiplier: 60x15 bits per cycle, truncate and clamp.
`timescale 1ns / 1ps

module rmch_mulq
    import rmch_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);
    localparam int CNT_W  = $clog2(NDIG + 1);
    localparam int PROD_W = 2 * MAG_W;

    logic [MAG_W-1:0]       ua_reg;
    logic [MAG_W-1:0]       ub_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    acc_t                   prod_reg;

    logic [MAG_W-1:0]       ma;
    logic [MAG_W-1:0]       mb;
    logic [MAG_W+DIG_W-1:0] part;
    logic [PROD_W-1:0]      acc_next;
    logic [PROD_W-1:0]      shifted;
    logic [MAG_W-1:0]       mag;
    acc_t                   prod_next;

    // Operand magnitudes and one digit step, most significant digit first
    always_comb
    begin
        ma       = req.a[ACC_W-1] ? MAG_W'(-req.a) : MAG_W'(req.a);
        mb       = req.b[ACC_W-1] ? MAG_W'(-req.b) : MAG_W'(req.b);
        part     = ua_reg * ub_reg[MAG_W-1 -: DIG_W];
        acc_next = (acc_reg << DIG_W) + PROD_W'(part);
        shifted  = acc_reg >> FRAC_BITS;
        mag      = (|shifted[PROD_W-1:MAG_W]) ? MAG_MAX : shifted[MAG_W-1:0];
        prod_next = neg_reg ? -acc_t'({1'b0, mag}) : acc_t'({1'b0, mag});
    end

    // Operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ua_reg  <= ma;
            ub_reg  <= mb;
            neg_reg <= req.a[ACC_W-1] ^ req.b[ACC_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            ub_reg  <= ub_reg << DIG_W;
        end
        if (busy_reg && cnt_reg == '0)
        begin
            prod_reg <= prod_next;
        end
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && cnt_reg == '0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NDIG);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;
endmodule

// ===== rtl/rmch_back.sv =====
// Back end: Moller-Trumbore sequence, distance divide, nearest hit and result.
`timescale 1ns / 1ps

module rmch_back
    import rmch_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  vec3_t     origin,
    input  vec3_t     dir,
    input  tri_item_t q_data,
    input  logic      q_empty,
    output logic      q_pop,
    output mul_req_t  mreq,
    input  mul_rsp_t  mrsp,
    rmch_hit_if.source hit_out
);
    localparam int DCNT_W = $clog2(DIST_W + 1);
    localparam int WIDE_W = MAG_W + DIST_W;
    localparam int INT_W  = DIST_W - FRAC_BITS;

    back_state_t             state_reg;
    back_state_t             state_next;
    tri_item_t               item_reg;
    logic [STEP_W-1:0]       k_reg;
    vec3_t                   p_reg;
    vec3_t                   q_reg;
    acc_t                    det_reg;
    acc_t                    un_reg;
    acc_t                    vn_reg;
    acc_t                    tn_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [MAG_W-1:0]        rem_reg;
    logic [DIST_W-1:0]       quo_reg;
    logic [DIST_W-1:0]       nsh_reg;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic [DIST_W-1:0]       best_reg;
    logic                    any_reg;
    logic [1:0]              axis_reg;
    logic signed [OUT_W-1:0] hx_reg;
    logic signed [OUT_W-1:0] hy_reg;
    logic signed [OUT_W-1:0] hz_reg;
    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic signed [OUT_W-1:0] out_x_reg;
    logic signed [OUT_W-1:0] out_y_reg;
    logic signed [OUT_W-1:0] out_z_reg;

    acc_t                    op_a;
    acc_t                    op_b;
    logic                    op_sub;
    logic                    op_first;
    logic                    op_end;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;
    acc_t                    nd;
    acc_t                    nun;
    acc_t                    nvn;
    acc_t                    ntn;
    logic                    accept;
    logic [MAG_W-1:0]        det_mag;
    logic [MAG_W-1:0]        tn_mag;
    logic                    dist_sat;
    logic [MAG_W:0]          trial;
    logic                    ge;
    acc_t                    org_axis;
    acc_t                    dir_axis;
    logic signed [SUM_W-1:0] hsum;
    logic signed [SUM_W-1:0] hclip;
    logic                    emit_load;

    // Operand schedule: cross products p = dir x e2, q = s x e1, then dot products
    always_comb
    begin
        op_a     = dir.y;
        op_b     = item_reg.e2.z;
        op_sub   = 1'b0;
        op_first = 1'b1;
        op_end   = 1'b0;
        case (k_reg)
            5'd0:  begin op_a = dir.y;         op_b = item_reg.e2.z; end
            5'd1:  begin op_a = dir.z;         op_b = item_reg.e2.y;
                         op_sub = 1'b1; op_first = 1'b0; op_end = 1'b1; end
            5'd2:  begin op_a = dir.z;         op_b = item_reg.e2.x; end
            5'd3:  begin op_a = dir.x;         op_b = item_reg.e2.z;
                         op_sub = 1'b1; op_first = 1'b0; op_end = 1'b1; end
            5'd4:  begin op_a = dir.x;         op_b = item_reg.e2.y; end
            5'd5:  begin op_a = dir.y;         op_b = item_reg.e2.x;
                         op_sub = 1'b1; op_first = 1'b0; op_end = 1'b1; end
            5'd6:  begin op_a = item_reg.s.y;  op_b = item_reg.e1.z; end
            5'd7:  begin op_a = item_reg.s.z;  op_b = item_reg.e1.y;
                         op_sub = 1'b1; op_first = 1'b0; op_end = 1'b1; end
            5'd8:  begin op_a = item_reg.s.z;  op_b = item_reg.e1.x; end
            5'd9:  begin op_a = item_reg.s.x;  op_b = item_reg.e1.z;
                         op_sub = 1'b1; op_first = 1'b0; op_end = 1'b1; end
            5'd10: begin op_a = item_reg.s.x;  op_b = item_reg.e1.y; end
            5'd11: begin op_a = item_reg.s.y;  op_b = item_reg.e1.x;
                         op_sub = 1'b1; op_first = 1'b0; op_end = 1'b1; end
            5'd12: begin op_a = item_reg.e1.x; op_b = p_reg.x; end
            5'd13: begin op_a = item_reg.e1.y; op_b = p_reg.y; op_first = 1'b0; end
            5'd14: begin op_a = item_reg.e1.z; op_b = p_reg.z;
                         op_first = 1'b0; op_end = 1'b1; end
            5'd15: begin op_a = item_reg.s.x;  op_b = p_reg.x; end
            5'd16: begin op_a = item_reg.s.y;  op_b = p_reg.y; op_first = 1'b0; end
            5'd17: begin op_a = item_reg.s.z;  op_b = p_reg.z;
                         op_first = 1'b0; op_end = 1'b1; end
            5'd18: begin op_a = dir.x;         op_b = q_reg.x; end
            5'd19: begin op_a = dir.y;         op_b = q_reg.y; op_first = 1'b0; end
            5'd20: begin op_a = dir.z;         op_b = q_reg.z;
                         op_first = 1'b0; op_end = 1'b1; end
            5'd21: begin op_a = item_reg.e2.x; op_b = q_reg.x; end
            5'd22: begin op_a = item_reg.e2.y; op_b = q_reg.y; op_first = 1'b0; end
            5'd23: begin op_a = item_reg.e2.z; op_b = q_reg.z;
                         op_first = 1'b0; op_end = 1'b1; end
            default: ;
        endcase
    end

    // Product accumulation
    always_comb
    begin
        term = op_sub ? -SUM_W'(mrsp.prod) : SUM_W'(mrsp.prod);
        sum  = op_first ? term : acc_reg + term;
    end

    // Orientation fold and inside test
    always_comb
    begin
        nd     = det_reg[ACC_W-1] ? -det_reg : det_reg;
        nun    = det_reg[ACC_W-1] ? -un_reg  : un_reg;
        nvn    = det_reg[ACC_W-1] ? -vn_reg  : vn_reg;
        ntn    = det_reg[ACC_W-1] ? -tn_reg  : tn_reg;
        accept = (det_reg != '0) && (nun >= 0) && (nun <= nd) && (nvn >= 0)
                 && (SUM_W'(nun) + SUM_W'(nvn) <= SUM_W'(nd)) && (ntn >= 0);
    end

    // Distance divide: overflow check and one restoring step
    always_comb
    begin
        det_mag  = det_reg[MAG_W-1:0];
        tn_mag   = tn_reg[MAG_W-1:0];
        dist_sat = WIDE_W'(tn_mag) >= (WIDE_W'(det_mag) << INT_W);
        trial    = {rem_reg, nsh_reg[DIST_W-1]};
        ge       = trial >= {1'b0, det_mag};
    end

    // Hit point for the current axis
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin org_axis = origin.x; dir_axis = dir.x; end
            2'd1:    begin org_axis = origin.y; dir_axis = dir.y; end
            default: begin org_axis = origin.z; dir_axis = dir.z; end
        endcase
        hsum = SUM_W'(org_axis) + SUM_W'(mrsp.prod);
        if (hsum > OUT_HI)
            hclip = OUT_HI;
        else if (hsum < OUT_LO)
            hclip = OUT_LO;
        else
            hclip = hsum;
    end

    assign emit_load = (state_reg == BK_EMIT) && (!out_valid_reg || hit_out.ready);

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mreq.start = 1'b0;
        mreq.a     = op_a;
        mreq.b     = op_b;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_MUL_ISSUE;
                end
            end
            BK_MUL_ISSUE:
            begin
                mreq.start = 1'b1;
                state_next = BK_MUL_WAIT;
            end
            BK_MUL_WAIT:
            begin
                if (mrsp.done)
                    state_next = (k_reg == STEP_W'(23)) ? BK_CLASSIFY : BK_MUL_ISSUE;
            end
            BK_CLASSIFY:  state_next = accept ? BK_DIV_CHECK : BK_FINISH;
            BK_DIV_CHECK: state_next = dist_sat ? BK_UPDATE : BK_DIV_STEP;
            BK_DIV_STEP:
            begin
                if (dcnt_reg == DCNT_W'(1))
                    state_next = BK_UPDATE;
            end
            BK_UPDATE:    state_next = BK_FINISH;
            BK_FINISH:
            begin
                if (!item_reg.last)
                    state_next = BK_IDLE;
                else if (any_reg)
                    state_next = BK_HIT_ISSUE;
                else
                    state_next = BK_EMIT;
            end
            BK_HIT_ISSUE:
            begin
                mreq.start = 1'b1;
                mreq.a     = dir_axis;
                mreq.b     = acc_t'({1'b0, MAG_W'(best_reg)});
                state_next = BK_HIT_WAIT;
            end
            BK_HIT_WAIT:
            begin
                if (mrsp.done)
                    state_next = (axis_reg == 2'd2) ? BK_EMIT : BK_HIT_ISSUE;
            end
            BK_EMIT:
            begin
                if (emit_load)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                item_reg <= q_data;
                k_reg    <= '0;
            end
            BK_MUL_WAIT:
            begin
                if (mrsp.done)
                begin
                    acc_reg <= sum;
                    k_reg   <= k_reg + 1'b1;
                    if (op_end)
                    begin
                        case (k_reg)
                            5'd1:    p_reg.x <= sat_acc(sum);
                            5'd3:    p_reg.y <= sat_acc(sum);
                            5'd5:    p_reg.z <= sat_acc(sum);
                            5'd7:    q_reg.x <= sat_acc(sum);
                            5'd9:    q_reg.y <= sat_acc(sum);
                            5'd11:   q_reg.z <= sat_acc(sum);
                            5'd14:   det_reg <= sat_acc(sum);
                            5'd17:   un_reg  <= sat_acc(sum);
                            5'd20:   vn_reg  <= sat_acc(sum);
                            default: tn_reg  <= sat_acc(sum);
                        endcase
                    end
                end
            end
            BK_CLASSIFY:
            begin
                det_reg <= nd;
                tn_reg  <= ntn;
            end
            BK_DIV_CHECK:
            begin
                quo_reg  <= DIST_MAX;
                rem_reg  <= tn_mag >> INT_W;
                nsh_reg  <= DIST_W'(tn_mag) << FRAC_BITS;
                dcnt_reg <= DCNT_W'(DIST_W);
            end
            BK_DIV_STEP:
            begin
                rem_reg  <= ge ? MAG_W'(trial - {1'b0, det_mag}) : MAG_W'(trial);
                quo_reg  <= {quo_reg[DIST_W-2:0], ge};
                nsh_reg  <= nsh_reg << 1;
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            BK_FINISH:
            begin
                axis_reg <= 2'd0;
                hx_reg   <= '0;
                hy_reg   <= '0;
                hz_reg   <= '0;
            end
            BK_HIT_WAIT:
            begin
                if (mrsp.done)
                begin
                    axis_reg <= axis_reg + 1'b1;
                    case (axis_reg)
                        2'd0:    hx_reg <= hclip[OUT_W-1:0];
                        2'd1:    hy_reg <= hclip[OUT_W-1:0];
                        default: hz_reg <= hclip[OUT_W-1:0];
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Nearest hit, cleared after each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= DIST_MAX;
            any_reg  <= 1'b0;
        end
        else if (state_reg == BK_UPDATE)
        begin
            if (!any_reg || quo_reg < best_reg)
            begin
                best_reg <= quo_reg;
                any_reg  <= 1'b1;
            end
        end
        else if (emit_load)
        begin
            best_reg <= DIST_MAX;
            any_reg  <= 1'b0;
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (hit_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_found_reg <= any_reg;
            out_dist_reg  <= best_reg;
            out_x_reg     <= hx_reg;
            out_y_reg     <= hy_reg;
            out_z_reg     <= hz_reg;
        end
    end

    assign hit_out.valid        = out_valid_reg;
    assign hit_out.hit_found    = out_found_reg;
    assign hit_out.nearest_dist = out_dist_reg;
    assign hit_out.hit_x        = out_x_reg;
    assign hit_out.hit_y        = out_y_reg;
    assign hit_out.hit_z        = out_z_reg;

    // Multiplier answers only while the sequencer waits for it
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> (state_reg == BK_MUL_WAIT || state_reg == BK_HIT_WAIT))
        else $error("multiplier result with no request outstanding");

    // Partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV_STEP) |-> (rem_reg < det_mag))
        else $error("divider remainder out of range");

    // Nearest-hit state returns to reset after a result is loaded
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> (!any_reg && best_reg == DIST_MAX))
        else $error("nearest-hit state not cleared after result");

    // A miss reports maximum distance and a zero point
    a_miss_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |->
        (out_dist_reg == DIST_MAX && out_x_reg == '0 && out_y_reg == '0 && out_z_reg == '0))
        else $error("miss result carries nonzero payload");
endmodule

// ===== rtl/ray_mesh_closest_hit.sv =====
// Closest hit of a configured ray against a stream of triangles.
// Each triangle takes 24 products on the shared serial multiplier; an accepted one
// whose distance does not saturate also takes 31 restoring divide steps. After the
// last triangle the hit point is formed on the same multiplier if a hit was found,
// then the result is loaded. The back end takes one triangle at a time, its pace set
// by the multiplier; a two-item queue keeps input accepted meanwhile.
// Reset: ray origin 0, direction (0, 0, 1.0), no hit held, queue and output empty.
`timescale 1ns / 1ps

module ray_mesh_closest_hit
    import rmch_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    rmch_tri_if.sink    tri_in,
    rmch_cfg_if.sink    cfg,
    rmch_hit_if.source  hit_out
);
    logic signed [COORD_WIDTH-1:0] org_x_reg;
    logic signed [COORD_WIDTH-1:0] org_y_reg;
    logic signed [COORD_WIDTH-1:0] org_z_reg;
    logic signed [COORD_WIDTH-1:0] dir_x_reg;
    logic signed [COORD_WIDTH-1:0] dir_y_reg;
    logic signed [COORD_WIDTH-1:0] dir_z_reg;

    vec3_t     origin;
    vec3_t     dir;
    logic      q_wr;
    tri_item_t q_wdata;
    logic      q_full;
    logic      q_pop;
    tri_item_t q_rdata;
    logic      q_empty;
    mul_req_t  mreq;
    mul_rsp_t  mrsp;

    assign cfg.ready = 1'b1;

    // Ray registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= COORD_WIDTH'(1) << FRAC_BITS;
        end
        else if (cfg.valid)
        begin
            case (cfg.idx)
                REG_ORG_X: org_x_reg <= cfg.data;
                REG_ORG_Y: org_y_reg <= cfg.data;
                REG_ORG_Z: org_z_reg <= cfg.data;
                REG_DIR_X: dir_x_reg <= cfg.data;
                REG_DIR_Y: dir_y_reg <= cfg.data;
                REG_DIR_Z: dir_z_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign origin.x = acc_t'(org_x_reg);
    assign origin.y = acc_t'(org_y_reg);
    assign origin.z = acc_t'(org_z_reg);
    assign dir.x    = acc_t'(dir_x_reg);
    assign dir.y    = acc_t'(dir_y_reg);
    assign dir.z    = acc_t'(dir_z_reg);

    rmch_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .tri_in  (tri_in),
        .origin  (origin),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full)
    );

    rmch_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    rmch_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    rmch_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .origin  (origin),
        .dir     (dir),
        .q_data  (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .mreq    (mreq),
        .mrsp    (mrsp),
        .hit_out (hit_out)
    );
endmodule
